// ===== rtl/core/mgrt_pkg.sv =====
`timescale 1ns / 1ps

package mgrt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int TREE_LEVELS = $clog2(MAX_ENTRIES);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int CNT_W       = $clog2(TREE_LEVELS + 1);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (COUNT_W > 7) ? COUNT_W : 7;

  localparam logic [6:0]  CAP_RESET   = 7'd64;
  localparam logic [31:0] GAP_NONE    = 32'hFFFF_FFFF;

  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_REDUCE
  } state_t;

  typedef struct packed {
    logic        command;
    logic [31:0] new_value;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [6:0]  entry_count;
    logic        span_valid;
    logic [31:0] shortest_span;
    logic [31:0] longest_span;
  } out_beat_t;

  typedef struct packed {
    logic capture;
    logic shift;
    logic occupied;
  } cell_ctl_t;

  // Exact distance between two signed 32-bit values.
  function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    begin
      if ($signed(a) < $signed(b)) begin
        d = b - a;
      end else begin
        d = a - b;
      end
      return d;
    end
  endfunction

endpackage

// ===== rtl/core/min_gap_and_range_tracker_unit.sv =====
`timescale 1ns / 1ps

// Bounded set of signed 32-bit values that tracks its closest pair and range.
// Input: a beat on in_beat is taken at a clock edge where start is high and
// busy is low. command adds new_value or clears the set.
// Output: each beat gives exactly one result on out_beat, shown for a single
// cycle with out_strobe high; the receiver cannot stall it.
// Configuration: cfg_we writes cfg_wdata into the capacity limit; write it only
// while busy is low and no result is outstanding.
// The values live in a row of cells that shift on each stored add. Every cell
// compares the new value with the value it holds in the accept cycle, and a
// registered min tree of TREE_LEVELS levels (6 for 64 entries) folds the gaps.
// The result is registered after the tree root. busy drops in the result cycle,
// so the unit takes no new beat until the last one has given its result.
// Reset empties the set, sets the capacity to 64 and clears any pending result.

module min_gap_and_range_tracker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mgrt_pkg::in_beat_t in_beat,
  output logic               out_strobe,
  output mgrt_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  localparam int N = mgrt_pkg::MAX_ENTRIES;

  mgrt_pkg::state_t state_r, state_nxt;
  logic [mgrt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mgrt_pkg::COUNT_W-1:0] held_count_r, held_count_nxt;
  logic [6:0]                   cap_r;
  logic [31:0]                  small_r, small_nxt;
  logic [31:0]                  large_r, large_nxt;
  logic [31:0]                  min_gap_r, min_gap_nxt;
  logic                         pending_add_r;
  logic                         status_r;
  logic                         out_strobe_r;
  mgrt_pkg::out_beat_t          out_beat_r, out_beat_nxt;

  logic                         accept;
  logic                         finish;
  logic                         full;
  logic                         add_ok;
  logic                         is_clear;
  logic [mgrt_pkg::CMP_W-1:0]   cap_ext;
  logic [mgrt_pkg::CMP_W-1:0]   eff_cap;
  logic [31:0]                  root;

  logic [31:0]                  cell_value [N];
  logic [31:0]                  cell_gap   [N];
  mgrt_pkg::cell_ctl_t          cell_ctl   [N];

  assign accept   = start & ~busy;
  assign is_clear = (in_beat.command == mgrt_pkg::CMD_CLEAR);

  always_comb begin
    cap_ext = mgrt_pkg::CMP_W'(cap_r);
    if (cap_ext > mgrt_pkg::CMP_W'(N)) begin
      eff_cap = mgrt_pkg::CMP_W'(N);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = mgrt_pkg::CMP_W'(held_count_r) >= eff_cap;
  assign add_ok = accept & ~is_clear & ~full;

  // Newest value enters cell 0; older values move one cell down the row.
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_ctl[i].capture  = add_ok;
    assign cell_ctl[i].shift    = add_ok;
    assign cell_ctl[i].occupied = mgrt_pkg::COUNT_W'(i) < held_count_r;

    if (i == 0) begin : g_head
      mgrt_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .probe     (in_beat.new_value),
        .data_in   (in_beat.new_value),
        .value_out (cell_value[i]),
        .gap_out   (cell_gap[i])
      );
    end else begin : g_body
      mgrt_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .probe     (in_beat.new_value),
        .data_in   (cell_value[i-1]),
        .value_out (cell_value[i]),
        .gap_out   (cell_gap[i])
      );
    end
  end

  mgrt_min_tree u_tree (
    .clk    (clk),
    .leaves (cell_gap),
    .root   (root)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      mgrt_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = mgrt_pkg::ST_REDUCE;
        end
      end
      mgrt_pkg::ST_REDUCE: begin
        if (cnt_r == mgrt_pkg::CNT_W'(mgrt_pkg::TREE_LEVELS)) begin
          state_nxt = mgrt_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = mgrt_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    busy   = 1'b0;
    finish = 1'b0;
    case (state_r)
      mgrt_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      mgrt_pkg::ST_REDUCE: begin
        busy   = 1'b1;
        finish = (cnt_r == mgrt_pkg::CNT_W'(mgrt_pkg::TREE_LEVELS));
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    held_count_nxt = held_count_r;
    small_nxt      = small_r;
    large_nxt      = large_r;
    min_gap_nxt    = min_gap_r;
    if (accept && is_clear) begin
      held_count_nxt = '0;
      small_nxt      = '0;
      large_nxt      = '0;
      min_gap_nxt    = mgrt_pkg::GAP_NONE;
    end else if (add_ok) begin
      held_count_nxt = held_count_r + 1'b1;
      if (held_count_r == '0) begin
        small_nxt = in_beat.new_value;
        large_nxt = in_beat.new_value;
      end else begin
        if ($signed(in_beat.new_value) < $signed(small_r)) begin
          small_nxt = in_beat.new_value;
        end
        if ($signed(large_r) < $signed(in_beat.new_value)) begin
          large_nxt = in_beat.new_value;
        end
      end
    end
    // The tree root holds this beat's smallest new gap by the last reduce cycle.
    if (finish && pending_add_r && (root < min_gap_r)) begin
      min_gap_nxt = root;
    end
  end

  always_comb begin
    out_beat_nxt.status      = status_r;
    out_beat_nxt.entry_count = 7'(held_count_r);
    out_beat_nxt.span_valid  = held_count_r >= mgrt_pkg::COUNT_W'(2);
    if (out_beat_nxt.span_valid) begin
      out_beat_nxt.shortest_span = min_gap_nxt;
      out_beat_nxt.longest_span  = large_r - small_r;
    end else begin
      out_beat_nxt.shortest_span = '0;
      out_beat_nxt.longest_span  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mgrt_pkg::ST_IDLE;
      cnt_r         <= '0;
      held_count_r  <= '0;
      cap_r         <= mgrt_pkg::CAP_RESET;
      small_r       <= '0;
      large_r       <= '0;
      min_gap_r     <= mgrt_pkg::GAP_NONE;
      pending_add_r <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      held_count_r <= held_count_nxt;
      small_r      <= small_nxt;
      large_r      <= large_nxt;
      min_gap_r    <= min_gap_nxt;
      out_strobe_r <= finish;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        pending_add_r <= add_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= (!is_clear && full) ? mgrt_pkg::STATUS_FULL : mgrt_pkg::STATUS_OK;
    end
    if (finish) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

  a_strobe_after_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == mgrt_pkg::ST_REDUCE))
    else $error("result strobe without a finished reduction");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= mgrt_pkg::COUNT_W'(N))
    else $error("entry count exceeds the cell row");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mgrt_pkg::ST_IDLE) |-> (cnt_r == '0))
    else $error("reduction counter not cleared while idle");

  a_no_gap_change_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mgrt_pkg::ST_IDLE) && !accept |=> $stable(min_gap_r))
    else $error("minimum gap changed with no beat in flight");

endmodule

// ===== rtl/core/mgrt_cell.sv =====
`timescale 1ns / 1ps

module mgrt_cell (
  input  logic               clk,
  input  mgrt_pkg::cell_ctl_t ctl,
  input  logic [31:0]        probe,
  input  logic [31:0]        data_in,
  output logic [31:0]        value_out,
  output logic [31:0]        gap_out
);

  logic [31:0] value_r;
  logic [31:0] gap_r;
  logic [31:0] gap_nxt;

  // An empty cell offers no pair, so it reports the largest possible gap.
  always_comb begin
    if (ctl.occupied) begin
      gap_nxt = mgrt_pkg::abs_gap(probe, value_r);
    end else begin
      gap_nxt = mgrt_pkg::GAP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      gap_r <= gap_nxt;
    end
    if (ctl.shift) begin
      value_r <= data_in;
    end
  end

  assign value_out = value_r;
  assign gap_out   = gap_r;

endmodule

// ===== rtl/core/mgrt_min_tree.sv =====
`timescale 1ns / 1ps

module mgrt_min_tree (
  input  logic        clk,
  input  logic [31:0] leaves [mgrt_pkg::MAX_ENTRIES],
  output logic [31:0] root
);

  localparam int P = mgrt_pkg::TREE_LEAVES;

  // Heap order: node j has children 2j and 2j+1; leaves sit at P..2P-1.
  logic [31:0] node_r [1:P-1];
  logic [31:0] all_w  [1:2*P-1];

  always_comb begin
    for (int j = 1; j < P; j++) begin
      all_w[j] = node_r[j];
    end
    for (int k = 0; k < P; k++) begin
      if (k < mgrt_pkg::MAX_ENTRIES) begin
        all_w[P + k] = leaves[k];
      end else begin
        all_w[P + k] = mgrt_pkg::GAP_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j < P; j++) begin
      if (all_w[2 * j] < all_w[2 * j + 1]) begin
        node_r[j] <= all_w[2 * j];
      end else begin
        node_r[j] <= all_w[2 * j + 1];
      end
    end
  end

  assign root = node_r[1];

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 100;

  typedef struct {
    logic                 is_setting;
    logic [6:0]           capacity;
    mgrt_pkg::in_beat_t   beat;
    logic                 known;
    mgrt_pkg::out_beat_t  want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  mgrt_pkg::in_beat_t  in_beat = '0;
  logic                out_strobe;
  mgrt_pkg::out_beat_t out_beat;
  logic                cfg_we = 1'b0;
  logic [6:0]          cfg_wdata = '0;

  // Mirror of the tracked set, updated at each accepted beat.
  logic [31:0] held_vals [mgrt_pkg::MAX_ENTRIES];
  int          held_total = 0;
  logic [31:0] lowest_val = '0;
  logic [31:0] highest_val = '0;
  logic [31:0] closest_gap = mgrt_pkg::GAP_NONE;
  logic [6:0]  capacity_setting = mgrt_pkg::CAP_RESET;

  plan_row_t           plan [$];
  mgrt_pkg::out_beat_t pending_results [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        beats_sent = 0;
  int        full_rejects = 0;
  int        clears_sent = 0;
  int        settings_used = 0;
  int        most_held = 0;

  min_gap_and_range_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_strobe(out_strobe),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic mgrt_pkg::out_beat_t mk_result(logic status, int count, logic valid,
                                                    logic [31:0] shortest,
                                                    logic [31:0] longest);
    mgrt_pkg::out_beat_t r;
    r.status        = status;
    r.entry_count   = count[6:0];
    r.span_valid    = valid;
    r.shortest_span = shortest;
    r.longest_span  = longest;
    return r;
  endfunction

  function automatic plan_row_t setting_row(logic [6:0] capacity);
    plan_row_t r;
    r = '{1'b1, capacity, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t beat_row(logic command, logic [31:0] value);
    plan_row_t r;
    r = '{1'b0, '0, '{command, value}, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t known_row(logic command, logic [31:0] value,
                                          mgrt_pkg::out_beat_t want);
    plan_row_t r;
    r = '{1'b0, '0, '{command, value}, 1'b1, want};
    return r;
  endfunction

  task automatic add_plan(input plan_row_t r);
    plan.insert(plan.size(), r);
  endtask

  // Applies one beat to the mirrored set and returns the result it must produce.
  function automatic mgrt_pkg::out_beat_t track_beat(mgrt_pkg::in_beat_t b);
    mgrt_pkg::out_beat_t r;
    int room;
    longint diff;
    room = (capacity_setting > mgrt_pkg::MAX_ENTRIES) ? mgrt_pkg::MAX_ENTRIES
                                                      : int'(capacity_setting);
    r = '0;
    r.status = mgrt_pkg::STATUS_OK;
    if (b.command == mgrt_pkg::CMD_CLEAR) begin
      held_total  = 0;
      lowest_val  = '0;
      highest_val = '0;
      closest_gap = mgrt_pkg::GAP_NONE;
    end else if (held_total >= room) begin
      r.status = mgrt_pkg::STATUS_FULL;
    end else begin
      for (int i = 0; i < held_total; i++) begin
        diff = longint'($signed(b.new_value)) - longint'($signed(held_vals[i]));
        if (diff < 0) diff = -diff;
        if (diff[31:0] < closest_gap) closest_gap = diff[31:0];
      end
      if (held_total == 0) begin
        lowest_val  = b.new_value;
        highest_val = b.new_value;
      end else begin
        if ($signed(b.new_value) < $signed(lowest_val)) lowest_val = b.new_value;
        if ($signed(b.new_value) > $signed(highest_val)) highest_val = b.new_value;
      end
      held_vals[held_total] = b.new_value;
      held_total++;
    end
    r.entry_count = held_total[6:0];
    if (held_total >= 2) begin
      r.span_valid    = 1'b1;
      r.shortest_span = closest_gap;
      r.longest_span  = highest_val - lowest_val;
    end
    return r;
  endfunction

  // Leaves start high after the handshake so that back-to-back beats need no
  // second assignment in the same step.
  task automatic send_beat(input mgrt_pkg::in_beat_t b, input logic known,
                           input mgrt_pkg::out_beat_t want);
    mgrt_pkg::out_beat_t predicted;
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = track_beat(b);
    pending_results.insert(pending_results.size(), known ? want : predicted);
    beats_sent++;
    if (b.command == mgrt_pkg::CMD_CLEAR) clears_sent++;
    if (predicted.status == mgrt_pkg::STATUS_FULL) full_rejects++;
    if (held_total > most_held) most_held = held_total;
  endtask

  // Sender gaps: light at first, heavy in the middle third, none at the end.
  task automatic idle_after_beat();
    int pct;
    int gap;
    pct = (beats_sent < 400) ? 17 : (beats_sent < 800) ? 79 : 0;
    if ($urandom_range(0, 99) < pct) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [6:0] capacity);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= capacity;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_setting = capacity;
    settings_used++;
  endtask

  always @(posedge clk) begin
    mgrt_pkg::out_beat_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending: %p", out_beat);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_beat.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_beat.status);
          mismatches++;
        end
        if (out_beat.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_beat.entry_count);
          mismatches++;
        end
        if (out_beat.span_valid !== want.span_valid) begin
          $error("span_valid: expected %0d, got %0d", want.span_valid, out_beat.span_valid);
          mismatches++;
        end
        if (out_beat.shortest_span !== want.shortest_span) begin
          $error("shortest_span: expected %h, got %h", want.shortest_span,
                 out_beat.shortest_span);
          mismatches++;
        end
        if (out_beat.longest_span !== want.longest_span) begin
          $error("longest_span: expected %h, got %h", want.longest_span,
                 out_beat.longest_span);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [6:0]         first_caps [6];
    int                 clear_pcts [4];
    logic [6:0]         cap;
    int                 clear_pct;
    logic [31:0]        phase_base;
    mgrt_pkg::in_beat_t b;

    first_caps = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd65, 7'd2};
    clear_pcts = '{1, 3, 8, 25};

    // Directed part. Capacity starts at its reset value of 64.
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'd5,
                       mk_result(mgrt_pkg::STATUS_OK, 1, 0, 0, 0)));
    // A duplicate gives a zero shortest span.
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'd5,
                       mk_result(mgrt_pkg::STATUS_OK, 2, 1, 0, 0)));
    add_plan(known_row(mgrt_pkg::CMD_CLEAR, 32'hFFFF_FFFF,
                       mk_result(mgrt_pkg::STATUS_OK, 0, 0, 0, 0)));
    add_plan(known_row(mgrt_pkg::CMD_CLEAR, 32'h0,
                       mk_result(mgrt_pkg::STATUS_OK, 0, 0, 0, 0)));
    // The two extremes give the widest span, which must not overflow.
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'h8000_0000,
                       mk_result(mgrt_pkg::STATUS_OK, 1, 0, 0, 0)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'h7FFF_FFFF,
                       mk_result(mgrt_pkg::STATUS_OK, 2, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'h0,
                       mk_result(mgrt_pkg::STATUS_OK, 3, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'hFFFF_FFFF,
                       mk_result(mgrt_pkg::STATUS_OK, 4, 1, 32'd1, 32'hFFFF_FFFF)));
    add_plan(beat_row(mgrt_pkg::CMD_ADD, 32'h1234_5678));
    // Capacity dropped below the count: values are kept, adds are refused.
    add_plan(setting_row(7'd2));
    add_plan(beat_row(mgrt_pkg::CMD_ADD, 32'h55AA_55AA));
    add_plan(known_row(mgrt_pkg::CMD_CLEAR, 32'h0,
                       mk_result(mgrt_pkg::STATUS_OK, 0, 0, 0, 0)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'hFFFF_FFF9,
                       mk_result(mgrt_pkg::STATUS_OK, 1, 0, 0, 0)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'd9,
                       mk_result(mgrt_pkg::STATUS_OK, 2, 1, 32'd16, 32'd16)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'd100,
                       mk_result(mgrt_pkg::STATUS_FULL, 2, 1, 32'd16, 32'd16)));
    // With zero capacity every add is refused.
    add_plan(setting_row(7'd0));
    add_plan(known_row(mgrt_pkg::CMD_CLEAR, 32'h0,
                       mk_result(mgrt_pkg::STATUS_OK, 0, 0, 0, 0)));
    add_plan(known_row(mgrt_pkg::CMD_ADD, 32'd1,
                       mk_result(mgrt_pkg::STATUS_FULL, 0, 0, 0, 0)));
    add_plan(setting_row(7'd127));
    add_plan(beat_row(mgrt_pkg::CMD_ADD, 32'hDEAD_BEEF));
    add_plan(beat_row(mgrt_pkg::CMD_ADD, 32'h0F0F_0F0F));
    add_plan(beat_row(mgrt_pkg::CMD_ADD, 32'hDEAD_BEEE));
    add_plan(beat_row(mgrt_pkg::CMD_CLEAR, 32'h0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_setting) begin
        write_capacity(plan[i].capacity);
      end else begin
        send_beat(plan[i].beat, plan[i].known, plan[i].want);
        idle_after_beat();
      end
    end

    // Random phases. The first runs above the bound with no clears, so the
    // set fills to the hardware limit and further adds are refused.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) begin
        cap = first_caps[phase];
      end else begin
        cap = $urandom_range(0, 1) ? 7'($urandom_range(0, 8)) : 7'($urandom_range(0, 127));
      end
      clear_pct  = (phase == 0) ? 0 : clear_pcts[$urandom_range(0, 3)];
      phase_base = $urandom;
      write_capacity(cap);
      repeat (PHASE_BEATS) begin
        b.command = ($urandom_range(0, 99) < clear_pct) ? mgrt_pkg::CMD_CLEAR
                                                        : mgrt_pkg::CMD_ADD;
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 4))
              0: b.new_value = 32'h8000_0000;
              1: b.new_value = 32'h7FFF_FFFF;
              2: b.new_value = 32'hFFFF_FFFF;
              3: b.new_value = 32'h0;
              default: b.new_value = 32'h1;
            endcase
          end
          1, 2, 3, 4: b.new_value = $urandom;
          // Clustered values give small gaps and duplicates.
          5, 6, 7: b.new_value = phase_base + $urandom_range(0, 31) - 32'd16;
          default: begin
            b.new_value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) b.new_value = -b.new_value;
          end
        endcase
        send_beat(b, 1'b0, '0);
        idle_after_beat();
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * (mgrt_pkg::TREE_LEVELS + 2)) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Sent %0d beats (%0d clears, %0d refused as full) under %0d capacity settings;",
             beats_sent, clears_sent, full_rejects, settings_used);
    $display("the set held up to %0d values; %0d field mismatches.", most_held, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mgrt_pkg.sv
rtl/core/mgrt_cell.sv
rtl/core/mgrt_min_tree.sv
rtl/core/min_gap_and_range_tracker_unit.sv
sim/testbench.sv
